### rtl/pldt_pkg.sv
// ----------------------------------------------------------------------------
// pldt_pkg
// Shared types and constants for the piecewise-linear damage table.
// ----------------------------------------------------------------------------
package pldt_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

    // Fixed field widths.
    localparam int unsigned OPEN_W   = 32;
    localparam int unsigned DMG_W    = 16;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned POS_W    = CNT_W + 1;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned DIV_CNT_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b1;

    // Item actions.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ORDER = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_START,
        ST_WR_CHECK,
        ST_EV_START,
        ST_EV_LAST,
        ST_SRCH_READ,
        ST_SRCH_CMP,
        ST_LOW_CAP,
        ST_HIGH_CAP,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH,
        ST_PUSH
    } state_t;

    // Which table position the read port fetches.
    typedef enum logic [2:0] {
        RD_PRED,
        RD_LAST,
        RD_PROBE,
        RD_LOW,
        RD_HIGH
    } rd_sel_t;

    // Which value the pending result takes.
    typedef enum logic [2:0] {
        RES_RANGE,
        RES_WRITE,
        RES_ZERO,
        RES_ENTRY,
        RES_INTERP
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        logic     res_en;
        res_sel_t res_sel;
        logic     srch_init;
        logic     srch_step;
        logic     cap_low;
        logic     setup;
        logic     mul;
        logic     div_init;
        logic     div_step;
        logic     push;
    } cmd_t;

    typedef struct packed {
        logic idx_bad;
        logic wr_bad;
        logic early_zero;
        logic past_last;
        logic srch_done;
        logic degen;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

### rtl/pldt_datapath.sv
// ----------------------------------------------------------------------------
// pldt_datapath
// Configuration registers, breakpoint memories, search registers,
// multiplier, restoring divider and the output register.
// ----------------------------------------------------------------------------
module pldt_datapath
    import pldt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [OPEN_W-1:0]    cfg_data,
    input  logic                 action,
    input  logic [CNT_W-1:0]     entry_index,
    input  logic [OPEN_W-1:0]    entry_jump,
    input  logic [DMG_W-1:0]     entry_damage,
    input  logic [OPEN_W-1:0]    opening,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [DMG_W-1:0]     damage,
    output logic [STAT_W-1:0]    status,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int unsigned ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
    localparam int unsigned CNT_CAP = (TABLE_DEPTH < CNT_MAX) ? TABLE_DEPTH : CNT_MAX;
    localparam int unsigned PROD_W  = DMG_W + OPEN_W;

    logic [OPEN_W-1:0] threshold_reg;
    logic [CNT_W-1:0]  entry_count_reg;

    logic              act_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [OPEN_W-1:0] jump_reg;
    logic [DMG_W-1:0]  dmg_reg;
    logic [OPEN_W-1:0] kappa_reg;

    logic [OPEN_W-1:0] jump_mem [TABLE_DEPTH];
    logic [DMG_W-1:0]  dmg_mem  [TABLE_DEPTH];
    logic [OPEN_W-1:0] rd_jump_reg;
    logic [DMG_W-1:0]  rd_dmg_reg;
    logic              rd_zero_reg;

    logic [POS_W-1:0]  first_reg;
    logic [POS_W-1:0]  count_reg;
    logic [POS_W-1:0]  probe_reg;

    logic [OPEN_W-1:0] x0_reg;
    logic [DMG_W-1:0]  y0_reg;
    logic [OPEN_W-1:0] den_reg;
    logic [OPEN_W-1:0] num_reg;
    logic [DMG_W-1:0]  dy_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [OPEN_W-1:0] rem_reg;
    logic [DMG_W-1:0]  quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [DMG_W-1:0]  res_dmg_reg;
    logic [STAT_W-1:0] res_stat_reg;
    logic              out_valid_reg;
    logic [DMG_W-1:0]  out_dmg_reg;
    logic [STAT_W-1:0] out_stat_reg;

    logic [CNT_W-1:0]  n_c;
    logic [OPEN_W-1:0] ent_x;
    logic [DMG_W-1:0]  ent_y;
    logic [POS_W-1:0]  step_c;
    logic [POS_W-1:0]  pos_c;
    logic [POS_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [OPEN_W:0]   jump_sum;
    logic [OPEN_W-1:0] abs_jump;
    logic [OPEN_W:0]   trial;
    logic              trial_ge;
    logic [OPEN_W:0]   trial_diff;

    // Effective breakpoint count, limited by the table depth.
    assign n_c = (entry_count_reg > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : entry_count_reg;

    // Position zero is the implicit (threshold, 0) breakpoint.
    assign ent_x = rd_zero_reg ? threshold_reg : rd_jump_reg;
    assign ent_y = rd_zero_reg ? '0 : rd_dmg_reg;

    assign step_c = count_reg >> 1;

    always_comb
    begin
        if (first_reg == '0)
        begin
            pos_c = POS_W'(1);
        end
        else if (first_reg > {1'b0, n_c})
        begin
            pos_c = {1'b0, n_c};
        end
        else
        begin
            pos_c = first_reg;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PRED:  rd_idx = {1'b0, idx_reg} - POS_W'(1);
            RD_LAST:  rd_idx = {1'b0, n_c};
            RD_PROBE: rd_idx = first_reg + step_c;
            RD_LOW:   rd_idx = pos_c - POS_W'(1);
            RD_HIGH:  rd_idx = pos_c;
            default:  rd_idx = '0;
        endcase
    end

    // Position i lives at address i-1; position zero never reaches the memory.
    assign raddr = ADDR_W'(rd_idx - POS_W'(1));
    assign waddr = ADDR_W'(idx_reg - CNT_W'(1));

    assign jump_sum = {1'b0, jump_reg} + {1'b0, threshold_reg};
    assign abs_jump = jump_sum[OPEN_W] ? '1 : jump_sum[OPEN_W-1:0];

    assign trial      = {rem_reg, quo_reg[DMG_W-1]};
    assign trial_ge   = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};

    assign sts.idx_bad    = (idx_reg == '0) || (idx_reg > n_c);
    assign sts.wr_bad     = (abs_jump < ent_x) || (dmg_reg < ent_y);
    assign sts.early_zero = (kappa_reg <= threshold_reg) || (n_c == '0);
    assign sts.past_last  = kappa_reg >= ent_x;
    assign sts.srch_done  = count_reg == '0;
    assign sts.degen      = ent_x <= x0_reg;
    assign sts.div_last   = div_cnt_reg == DIV_CNT_W'(DMG_W - 1);
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= '0;
            entry_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD:   threshold_reg   <= cfg_data;
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Breakpoint memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            jump_mem[waddr] <= abs_jump;
            dmg_mem[waddr]  <= dmg_reg;
        end
        if (cmd.rd_en)
        begin
            rd_jump_reg <= jump_mem[raddr];
            rd_dmg_reg  <= dmg_mem[raddr];
            rd_zero_reg <= rd_idx == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            idx_reg   <= entry_index;
            jump_reg  <= entry_jump;
            dmg_reg   <= entry_damage;
            kappa_reg <= opening;
        end

        if (cmd.srch_init)
        begin
            first_reg <= '0;
            count_reg <= {1'b0, n_c} + POS_W'(1);
        end
        else if (cmd.srch_step)
        begin
            if (ent_x < kappa_reg)
            begin
                first_reg <= probe_reg + POS_W'(1);
                count_reg <= count_reg - step_c - POS_W'(1);
            end
            else
            begin
                count_reg <= step_c;
            end
        end

        if (cmd.rd_en && (cmd.rd_sel == RD_PROBE))
        begin
            probe_reg <= rd_idx;
        end

        if (cmd.cap_low)
        begin
            x0_reg <= ent_x;
            y0_reg <= ent_y;
        end

        if (cmd.setup)
        begin
            den_reg <= ent_x - x0_reg;
            if (kappa_reg <= x0_reg)
            begin
                num_reg <= '0;
            end
            else if (kappa_reg >= ent_x)
            begin
                num_reg <= ent_x - x0_reg;
            end
            else
            begin
                num_reg <= kappa_reg - x0_reg;
            end
            neg_reg <= ent_y < y0_reg;
            dy_reg  <= (ent_y < y0_reg) ? (y0_reg - ent_y) : (ent_y - y0_reg);
        end

        if (cmd.mul)
        begin
            prod_reg <= {{OPEN_W{1'b0}}, dy_reg} * {{DMG_W{1'b0}}, num_reg};
        end

        // The quotient fits in 16 bits, so the upper product bits start
        // below the divisor.
        if (cmd.div_init)
        begin
            rem_reg     <= prod_reg[PROD_W-1:DMG_W];
            quo_reg     <= prod_reg[DMG_W-1:0];
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= trial_ge ? trial_diff[OPEN_W-1:0] : trial[OPEN_W-1:0];
            quo_reg     <= {quo_reg[DMG_W-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.res_en)
        begin
            case (cmd.res_sel)
                RES_RANGE:
                begin
                    res_dmg_reg  <= '0;
                    res_stat_reg <= STATUS_RANGE;
                end
                RES_WRITE:
                begin
                    res_dmg_reg  <= '0;
                    res_stat_reg <= sts.wr_bad ? STATUS_ORDER : STATUS_OK;
                end
                RES_ENTRY:
                begin
                    res_dmg_reg  <= ent_y;
                    res_stat_reg <= STATUS_OK;
                end
                RES_INTERP:
                begin
                    res_dmg_reg  <= neg_reg ? (y0_reg - quo_reg) : (y0_reg + quo_reg);
                    res_stat_reg <= STATUS_OK;
                end
                default:
                begin
                    res_dmg_reg  <= '0;
                    res_stat_reg <= STATUS_OK;
                end
            endcase
        end

        if (cmd.push)
        begin
            out_dmg_reg  <= act_reg == ACT_EVAL ? res_dmg_reg : '0;
            out_stat_reg <= res_stat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign damage    = out_dmg_reg;
    assign status    = out_stat_reg;

endmodule

### rtl/pldt_ctrl.sv
// ----------------------------------------------------------------------------
// pldt_ctrl
// Sequencer for write and evaluate items: table reads, binary search,
// multiply, divide and result transfer.
// ----------------------------------------------------------------------------
module pldt_ctrl
    import pldt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic action,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_sel    = RD_PRED;
        cmd.wr_en     = 1'b0;
        cmd.res_en    = 1'b0;
        cmd.res_sel   = RES_ZERO;
        cmd.srch_init = 1'b0;
        cmd.srch_step = 1'b0;
        cmd.cap_low   = 1'b0;
        cmd.setup     = 1'b0;
        cmd.mul       = 1'b0;
        cmd.div_init  = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.push      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (action == ACT_EVAL) ? ST_EV_START : ST_WR_START;
                end
            end
            ST_WR_START:
            begin
                if (sts.idx_bad)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_RANGE;
                    state_next  = ST_PUSH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PRED;
                    state_next = ST_WR_CHECK;
                end
            end
            ST_WR_CHECK:
            begin
                cmd.wr_en   = !sts.wr_bad;
                cmd.res_en  = 1'b1;
                cmd.res_sel = RES_WRITE;
                state_next  = ST_PUSH;
            end
            ST_EV_START:
            begin
                if (sts.early_zero)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_ZERO;
                    state_next  = ST_PUSH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                    state_next = ST_EV_LAST;
                end
            end
            ST_EV_LAST:
            begin
                if (sts.past_last)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_ENTRY;
                    state_next  = ST_PUSH;
                end
                else
                begin
                    cmd.srch_init = 1'b1;
                    state_next    = ST_SRCH_READ;
                end
            end
            ST_SRCH_READ:
            begin
                cmd.rd_en = 1'b1;
                if (sts.srch_done)
                begin
                    cmd.rd_sel = RD_LOW;
                    state_next = ST_LOW_CAP;
                end
                else
                begin
                    cmd.rd_sel = RD_PROBE;
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP:
            begin
                cmd.srch_step = 1'b1;
                state_next    = ST_SRCH_READ;
            end
            ST_LOW_CAP:
            begin
                cmd.cap_low = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_HIGH;
                state_next  = ST_HIGH_CAP;
            end
            ST_HIGH_CAP:
            begin
                // A segment that does not rise in opening answers its upper damage.
                if (sts.degen)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_ENTRY;
                    state_next  = ST_PUSH;
                end
                else
                begin
                    cmd.setup  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.res_en  = 1'b1;
                cmd.res_sel = RES_INTERP;
                state_next  = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/piecewise_linear_damage_table.sv
// Write item: the predecessor is read and the order check decides the write, then the result
// is pushed; an index out of range answers without the read. One item is in flight at a time.
// Evaluate item: a binary search over positions 0..count, each probe a read and a compare on
// the single memory read port, then a multiply and the 16-step restoring divider.
// Early answers (at or below threshold, count 0, past the last breakpoint) skip the search.
// Reset clears threshold, entry_count and the controller; breakpoint memories are not reset.
// ----------------------------------------------------------------------------
// piecewise_linear_damage_table
// Breakpoint table with binary search and linear interpolation of damage.
// ----------------------------------------------------------------------------
module piecewise_linear_damage_table
    import pldt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [OPEN_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [CNT_W-1:0]     entry_index,
    input  logic [OPEN_W-1:0]    entry_jump,
    input  logic [DMG_W-1:0]     entry_damage,
    input  logic [OPEN_W-1:0]    opening,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DMG_W-1:0]     damage,
    output logic [STAT_W-1:0]    status
);

    cmd_t cmd;
    sts_t sts;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    pldt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    pldt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .entry_index  (entry_index),
        .entry_jump   (entry_jump),
        .entry_damage (entry_damage),
        .opening      (opening),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .damage       (damage),
        .status       (status),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

### rtl/pldt_checker.sv
// ----------------------------------------------------------------------------
// pldt_checker
// Port-level checks for the damage table, bound to the top level.
// ----------------------------------------------------------------------------
module pldt_checker
    import pldt_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [OPEN_W-1:0]    cfg_data,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 action,
    input logic [CNT_W-1:0]     entry_index,
    input logic [OPEN_W-1:0]    entry_jump,
    input logic [DMG_W-1:0]     entry_damage,
    input logic [OPEN_W-1:0]    opening,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [DMG_W-1:0]     damage,
    input logic [STAT_W-1:0]    status
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(damage) && $stable(status))
        else $error("result changed while stalled");

    // One item at a time: an input transfer is followed by a busy cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // A new result appears only while the block is busy with an item.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an item in flight");

    // Rejected writes carry zero damage, and no status code beyond range.
    a_status_damage: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK) || (damage == '0 &&
            (status == STATUS_ORDER || status == STATUS_RANGE)))
        else $error("bad status or damage on a rejected write");

endmodule

bind piecewise_linear_damage_table pldt_checker u_pldt_checker (.*);

### tb/sv/tb_piecewise_linear_damage_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_damage_table
// Loads breakpoint tables under many threshold and count settings, evaluates
// damage around and between breakpoints, and checks every result against a
// behavioral predictor of the table, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_damage_table;
    import pldt_pkg::*;

    localparam int unsigned DEPTH         = DEFAULT_TABLE_DEPTH;
    localparam int unsigned ITEM_TARGET   = 1650;
    localparam int unsigned LIMIT_CYCLES  = 1500000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct packed {
        logic              action;
        logic [CNT_W-1:0]  entry_index;
        logic [OPEN_W-1:0] entry_jump;
        logic [DMG_W-1:0]  entry_damage;
        logic [OPEN_W-1:0] opening;
    } table_item_t;

    typedef struct packed {
        logic [DMG_W-1:0]  damage;
        logic [STAT_W-1:0] status;
    } table_result_t;

    // Tracks the breakpoint table and the results still owed by the block.
    class damage_table_scoreboard;
        bit [OPEN_W-1:0] threshold_q;
        bit [CNT_W-1:0]  count_q;
        bit [OPEN_W-1:0] jump_tab [1:DEPTH];
        bit [DMG_W-1:0]  damage_tab [1:DEPTH];
        bit              written [1:DEPTH];
        table_result_t   due_results [$];
        int unsigned     error_count;

        function int unsigned live_count();
            return (count_q < DEPTH) ? count_q : DEPTH;
        endfunction

        // Position 0 is the implicit breakpoint at the threshold with no damage.
        function bit [OPEN_W-1:0] jump_of(int unsigned k);
            return (k == 0) ? threshold_q : jump_tab[k];
        endfunction

        function bit [DMG_W-1:0] damage_of(int unsigned k);
            return (k == 0) ? '0 : damage_tab[k];
        endfunction

        function bit table_complete();
            for (int unsigned k = 1; k <= live_count(); k++)
            begin
                if (!written[k])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [OPEN_W-1:0] value);
            if (idx == REG_THRESHOLD)
                threshold_q = value;
            else if (idx == REG_ENTRY_COUNT)
                count_q = value[CNT_W-1:0];
        endfunction

        function bit [DMG_W-1:0] interpolate_damage(bit [OPEN_W-1:0] kappa);
            int unsigned     n, base, span, half, probe, pos;
            bit [OPEN_W-1:0] x0, x1, num, den;
            bit [DMG_W-1:0]  y0, y1;
            bit [63:0]       dy, q;
            n = live_count();
            if (kappa <= threshold_q || n == 0)
                return '0;
            if (kappa >= jump_of(n))
                return damage_of(n);
            // Lower bound over positions 0..n, clamped to 1..n afterwards.
            base = 0;
            span = n + 1;
            while (span > 0)
            begin
                half  = span / 2;
                probe = base + half;
                if (jump_of(probe) < kappa)
                begin
                    base = probe + 1;
                    span = span - (half + 1);
                end
                else
                    span = half;
            end
            pos = base;
            if (pos < 1)
                pos = 1;
            if (pos > n)
                pos = n;
            x0 = jump_of(pos - 1);
            x1 = jump_of(pos);
            y0 = damage_of(pos - 1);
            y1 = damage_of(pos);
            if (x1 <= x0)
                return y1;
            den = x1 - x0;
            num = (kappa > x0) ? kappa - x0 : '0;
            if (num > den)
                num = den;
            if (y1 >= y0)
            begin
                dy = y1 - y0;
                q  = (dy * num) / den;
                return y0 + q[DMG_W-1:0];
            end
            dy = y0 - y1;
            q  = (dy * num) / den;
            return y0 - q[DMG_W-1:0];
        endfunction

        function void note_item(table_item_t it);
            table_result_t   res;
            int unsigned     n, k;
            bit [OPEN_W:0]   wide;
            bit [OPEN_W-1:0] abs_jump;
            n = live_count();
            k = it.entry_index;
            res.damage = '0;
            res.status = STATUS_OK;
            if (it.action == ACT_EVAL)
                res.damage = interpolate_damage(it.opening);
            else if (k == 0 || k > n)
                res.status = STATUS_RANGE;
            else
            begin
                wide = it.entry_jump + threshold_q;
                abs_jump = wide[OPEN_W] ? '1 : wide[OPEN_W-1:0];
                // Only the predecessor is compared; successors may end up lower.
                if (abs_jump < jump_of(k - 1) || it.entry_damage < damage_of(k - 1))
                    res.status = STATUS_ORDER;
                else
                begin
                    jump_tab[k]   = abs_jump;
                    damage_tab[k] = it.entry_damage;
                    written[k]    = 1'b1;
                end
            end
            due_results.push_back(res);
        endfunction

        function void check_result(logic [DMG_W-1:0] dmg, logic [STAT_W-1:0] st);
            table_result_t exp_res;
            if (due_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual damage %h status %0d",
                         $time, dmg, st);
            end
            else
            begin
                exp_res = due_results.pop_front();
                if (exp_res.damage !== dmg)
                begin
                    error_count++;
                    $display("%0t: damage mismatch, expected %h, actual %h",
                             $time, exp_res.damage, dmg);
                end
                if (exp_res.status !== st)
                begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_res.status, st);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [OPEN_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [CNT_W-1:0]     entry_index;
    logic [OPEN_W-1:0]    entry_jump;
    logic [DMG_W-1:0]     entry_damage;
    logic [OPEN_W-1:0]    opening;
    logic                 out_valid;
    logic                 out_ready;
    logic [DMG_W-1:0]     damage;
    logic [STAT_W-1:0]    status;

    damage_table_scoreboard sb;
    int unsigned            items_sent = 0;
    int unsigned            nogap_left = 0;
    int unsigned            cycle_count = 0;
    bit                     gapless = 1'b0;
    bit                     hold_req = 1'b0;

    piecewise_linear_damage_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .entry_index  (entry_index),
        .entry_jump   (entry_jump),
        .entry_damage (entry_damage),
        .opening      (opening),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .damage       (damage),
        .status       (status)
    );

    always #2 clk = ~clk;

    function automatic bit [31:0] rand_upto(bit [31:0] span);
        bit [63:0] r;
        r = {$urandom, $urandom};
        r = r % ({32'b0, span} + 64'd1);
        return r[31:0];
    endfunction

    function automatic bit [OPEN_W-1:0] sat_add32(bit [OPEN_W-1:0] a, bit [OPEN_W-1:0] b);
        bit [OPEN_W:0] t;
        t = a + b;
        return t[OPEN_W] ? '1 : t[OPEN_W-1:0];
    endfunction

    function automatic bit [DMG_W-1:0] sat_add16(bit [DMG_W-1:0] a, bit [DMG_W-1:0] b);
        bit [DMG_W:0] t;
        t = a + b;
        return t[DMG_W] ? '1 : t[DMG_W-1:0];
    endfunction

    // Spacing between consecutive breakpoints: sometimes none, mostly modest.
    function automatic bit [OPEN_W-1:0] jump_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 70)
            return $urandom_range(1, 'h4_0000);
        else if (r < 90)
            return $urandom_range(1, 'h100_0000);
        return $urandom;
    endfunction

    function automatic bit [DMG_W-1:0] damage_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        else if (r < 80)
            return DMG_W'($urandom_range(1, 'h800));
        return DMG_W'($urandom_range(1, 'hFFFF));
    endfunction

    // Unused fields of an item carry random values so that every bit toggles.
    function automatic table_item_t random_item(logic act);
        table_item_t it;
        it.action       = act;
        it.entry_index  = CNT_W'($urandom_range(0, 127));
        it.entry_jump   = $urandom;
        it.entry_damage = DMG_W'($urandom);
        it.opening      = $urandom;
        return it;
    endfunction

    task automatic push_item(input table_item_t it);
        in_valid     <= 1'b1;
        action       <= it.action;
        entry_index  <= it.entry_index;
        entry_jump   <= it.entry_jump;
        entry_damage <= it.entry_damage;
        opening      <= it.opening;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic sender_gap();
        int unsigned r, n;
        n = 0;
        if (nogap_left > 0)
            nogap_left--;
        else if (!gapless)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                n = 0;
            else if (r < 88)
                n = $urandom_range(1, 3);
            else if (r < 97)
                n = $urandom_range(4, 15);
            else
                n = $urandom_range(30, 80);
        end
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_write(input logic [CNT_W-1:0] idx, input logic [OPEN_W-1:0] jump,
                              input logic [DMG_W-1:0] dmg);
        table_item_t it;
        it              = random_item(ACT_WRITE);
        it.entry_index  = idx;
        it.entry_jump   = jump;
        it.entry_damage = dmg;
        push_item(it);
        sender_gap();
    endtask

    task automatic send_eval(input logic [OPEN_W-1:0] kappa);
        table_item_t it;
        it         = random_item(ACT_EVAL);
        it.opening = kappa;
        push_item(it);
        sender_gap();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OPEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    // Stops offering items and waits until every owed result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(damage, status);
    end

    // Result side: short and long stalls, calm stretches, and one long hold-off.
    initial
    begin
        int unsigned calm_left, busy_left, r;
        calm_left = 0;
        busy_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_ready <= 1'b1;
            end
            else if (busy_left > 0)
            begin
                busy_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    calm_left = $urandom_range(50, 200);
                else if (r < 8)
                    busy_left = $urandom_range(20, 60);
                else if (r < 30)
                    busy_left = $urandom_range(1, 3);
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int unsigned     r, k, j, n, burst, phase_no, cnt;
        bit [OPEN_W-1:0] thr, rel, lo, hi, absj, kappa;
        bit [DMG_W-1:0]  dmg, dlo, dhi;
        table_item_t     it;

        sb           = new();
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_THRESHOLD;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = ACT_WRITE;
        entry_index  = '0;
        entry_jump   = '0;
        entry_damage = '0;
        opening      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: everything evaluates to zero and every write is out of range.
        write_reg(REG_THRESHOLD, '0);
        write_reg(REG_ENTRY_COUNT, 0);
        send_eval('0);
        send_eval('1);
        send_write(1, 'h100, 'h10);
        send_write(0, 'h100, 'h10);
        drain();

        write_reg(REG_THRESHOLD, 'h1_0000);
        write_reg(REG_ENTRY_COUNT, 3);
        send_write(1, 'h8000, 'h1000);
        send_write(2, 'h1_0000, 'h0800);    // damage below predecessor
        send_write(2, 'h4000, 'h2000);      // opening below predecessor
        send_write(2, 'h2_0000, 'h8000);
        send_write(3, '1, 'hFFFF);          // saturates at the top
        send_write(4, '0, 'hFFFF);
        send_write(127, '0, '0);
        send_eval('h1_0000);
        send_eval('h1_0001);
        send_eval('h1_8000);
        send_eval('h2_4000);
        send_eval('h8000_0000);
        send_eval('1);
        send_eval('0);
        // Entry 1 now lies above entry 2, so the search runs on an unordered table.
        send_write(1, 'hFFFF_0000, 'h1000);
        send_eval('h2_0000);
        send_eval('h4_0000);
        drain();
        // Threshold moved above the stored breakpoint of entry 2.
        write_reg(REG_THRESHOLD, 'h10_0000);
        send_eval('h2_0000);
        send_eval('h20_0000);

        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            drain();
            r = $urandom_range(0, 99);
            if (r < 10)
                thr = '0;
            else if (r < 16)
                thr = '1;
            else if (r < 50)
                thr = $urandom_range(0, 'hF_FFFF);
            else
                thr = $urandom;
            r = $urandom_range(0, 99);
            if (r < 8)
                cnt = 0;
            else if (r < 16)
                cnt = DEPTH;
            else if (r < 70)
                cnt = $urandom_range(1, 8);
            else
                cnt = $urandom_range(1, DEPTH);
            if (phase_no == 0)
            begin
                thr = '1;
                cnt = 5;
            end
            else if (phase_no == 1)
            begin
                thr = $urandom_range(0, 'hFFFF);
                cnt = DEPTH;
            end
            else if (phase_no == 2)
            begin
                thr = '0;
                cnt = 0;
            end
            write_reg(REG_THRESHOLD, thr);
            write_reg(REG_ENTRY_COUNT, cnt);
            gapless = ($urandom_range(0, 3) == 0);
            n = sb.live_count();

            // Reload all entries in order if any is unwritten, else at random.
            if (!sb.table_complete() || $urandom_range(0, 2) != 0)
            begin
                rel = '0;
                dmg = '0;
                for (k = 1; k <= n; k++)
                begin
                    rel = sat_add32(rel, jump_step());
                    dmg = sat_add16(dmg, damage_step());
                    send_write(CNT_W'(k), rel, dmg);
                end
            end

            burst = $urandom_range(40, 120);
            for (j = 0; j < burst; j++)
            begin
                if (phase_no == 1 && j == 10)
                begin
                    hold_req   = 1'b1;
                    nogap_left = 24;
                end
                if ((phase_no == 1 && j == 60) || $urandom_range(0, 99) == 0)
                    drain();
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    r = $urandom_range(0, 99);
                    if (n == 0 || r < 10)
                        kappa = $urandom;
                    else if (r < 13)
                        kappa = '0;
                    else if (r < 16)
                        kappa = '1;
                    else if (r < 20)
                        kappa = sb.threshold_q;
                    else if (r < 26)
                        kappa = sb.jump_of(n) + $urandom_range(0, 'hFFFF);
                    else if (r < 45)
                    begin
                        k = $urandom_range(0, n);
                        kappa = sb.jump_of(k) + $urandom_range(0, 2) - 1;
                    end
                    else
                    begin
                        k  = $urandom_range(1, n);
                        lo = sb.jump_of(k - 1);
                        hi = sb.jump_of(k);
                        kappa = (hi >= lo) ? lo + rand_upto(hi - lo) : hi + rand_upto(lo - hi);
                    end
                    send_eval(kappa);
                end
                else if (r < 88 && n > 0)
                begin
                    // Rewrite an entry between its neighbors; the last within a step.
                    k  = $urandom_range(1, n);
                    lo = sb.jump_of(k - 1);
                    hi = (k < n) ? sb.jump_of(k + 1) : sat_add32(lo, jump_step());
                    if (hi < lo)
                        hi = lo;
                    absj = lo + rand_upto(hi - lo);
                    rel  = (absj >= sb.threshold_q) ? absj - sb.threshold_q : '0;
                    dlo  = sb.damage_of(k - 1);
                    dhi  = (k < n) ? sb.damage_of(k + 1) : sat_add16(dlo, damage_step());
                    if (dhi < dlo)
                        dhi = dlo;
                    dmg = dlo + DMG_W'(rand_upto(32'(dhi - dlo)));
                    send_write(CNT_W'(k), rel, dmg);
                end
                else
                begin
                    it = random_item(1'($urandom_range(0, 1)));
                    push_item(it);
                    sender_gap();
                end
            end
            phase_no++;
        end

        drain();
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
